FILE: rtl/core/date_add_days_assert.svh
// ----------------------------------------------------------------------------
// date_add_days_assert
// Assertion macros shared by the date_add_days modules.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define DAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("date_add_days assertion failed");
// consequent must hold in the cycle after the antecedent
`define DAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("date_add_days assertion failed");
`else
`define DAD_ASSERT(lbl, clk, rst_n, prop)
`define DAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types, constants and calendar helpers of the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int OFFSET_BITS = 20;

  localparam logic [13:0] YEAR_MIN = 14'd1601;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_FEB   = 5'd28;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

  // floor(y / 100) for y < 16384 as (y * 5243) >> 19
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [6:0]  YMOD_LAST    = 7'd99;

  typedef struct packed {
    logic load_in;
    logic calc_quot;
    logic calc_mod;
    logic check;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_bad;
    logic step_done;
  } sts_t;

  // leap from year mod 100 and century mod 4
  function automatic logic is_leap(input logic [6:0] ymod, input logic [1:0] cmod);
    logic leap;
    if (ymod == 7'd0) begin
      leap = (cmod == 2'd0);
    end else begin
      leap = (ymod[1:0] == 2'd0);
    end
    return leap;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] dim;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: dim = DAYS_SHORT;
      MONTH_FEB: dim = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      default:   dim = DAYS_LONG;
    endcase
    return dim;
  endfunction

endpackage

FILE: rtl/core/dad_if.sv
// ----------------------------------------------------------------------------
// dad_in_if / dad_out_if
// Valid/ready channels that carry start dates in and result dates out.
// ----------------------------------------------------------------------------
interface dad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [4:0]                           start_day;
  logic [3:0]                           start_month;
  logic [13:0]                          start_year;
  logic signed [dad_pkg::OFFSET_BITS-1:0] day_offset;

  modport source (output valid, start_day, start_month, start_year, day_offset,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, day_offset,
                output ready);
endinterface

interface dad_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  result_day;
  logic [3:0]  result_month;
  logic [13:0] result_year;
  logic        error;

  modport source (output valid, result_day, result_month, result_year, error,
                  input ready);
  modport sink (input valid, result_day, result_month, result_year, error,
                output ready);
endinterface

FILE: rtl/core/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath
// Date registers, leap tracking and the one-month-per-cycle stepper.
// ----------------------------------------------------------------------------
`include "date_add_days_assert.svh"

module dad_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dad_pkg::cmd_t                         cmd_i,
  output dad_pkg::sts_t                         sts_o,
  input  logic [4:0]                            start_day_i,
  input  logic [3:0]                            start_month_i,
  input  logic [13:0]                           start_year_i,
  input  logic signed [dad_pkg::OFFSET_BITS-1:0] day_offset_i,
  output logic [4:0]                            result_day_o,
  output logic [3:0]                            result_month_o,
  output logic [13:0]                           result_year_o,
  output logic                                  error_o
);
  import dad_pkg::*;

  logic [4:0]             sd_q;
  logic [3:0]             sm_q;
  logic [13:0]            sy_q;
  logic [OFFSET_BITS-1:0] off_q;

  logic [7:0]  quot_q;
  logic [26:0] quot_prod;
  logic [13:0] hund;
  logic [13:0] ymod_full;

  logic [6:0]  ymod_q, ymod_d;
  logic [1:0]  cmod_q, cmod_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [OFFSET_BITS-1:0] rem_q, rem_d;
  logic        neg_q;
  logic        err_q, err_d;

  logic [4:0]  res_day_q;
  logic [3:0]  res_month_q;
  logic [13:0] res_year_q;
  logic        res_err_q;

  logic       leap;
  logic [4:0] dim_start;
  logic [4:0] dim_cur;
  logic [3:0] prev_month;
  logic [4:0] dim_prev;
  logic [4:0] room;
  logic       start_bad;
  logic       fits;
  logic       at_edge;

  assign quot_prod = 27'(sy_q) * 27'(DIV100_MUL);
  assign hund      = 14'(quot_q) * 14'd100;
  assign ymod_full = sy_q - hund;

  assign leap      = is_leap(ymod_q, cmod_q);
  assign dim_start = days_in_month(sm_q, leap);
  assign dim_cur   = days_in_month(month_q, leap);
  assign prev_month = (month_q == MONTH_JAN) ? MONTH_DEC : month_q - 4'd1;
  // going back past january lands in december, 31 days whatever the year
  assign dim_prev  = days_in_month(prev_month, leap);
  assign room      = dim_cur - day_q;

  assign start_bad = (sy_q < YEAR_MIN) || (sy_q > YEAR_MAX) ||
                     (sm_q == 4'd0) || (sm_q > MONTH_DEC) ||
                     (sd_q == 5'd0) || (sd_q > dim_start);

  assign fits    = neg_q ? (rem_q < OFFSET_BITS'(day_q))
                         : (rem_q <= OFFSET_BITS'(room));
  assign at_edge = neg_q ? ((month_q == MONTH_JAN) && (year_q == YEAR_MIN))
                         : ((month_q == MONTH_DEC) && (year_q == YEAR_MAX));

  assign sts_o.start_bad = start_bad;
  assign sts_o.step_done = fits || at_edge;

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    rem_d   = rem_q;
    ymod_d  = ymod_q;
    cmod_d  = cmod_q;
    err_d   = err_q;
    if (cmd_i.calc_mod) begin
      ymod_d = ymod_full[6:0];
      cmod_d = quot_q[1:0];
    end else if (cmd_i.check) begin
      err_d   = start_bad;
      day_d   = sd_q;
      month_d = sm_q;
      year_d  = sy_q;
      rem_d   = off_q[OFFSET_BITS-1] ? (~off_q + OFFSET_BITS'(1)) : off_q;
    end else if (cmd_i.step) begin
      if (fits) begin
        day_d = neg_q ? (day_q - rem_q[4:0]) : (day_q + rem_q[4:0]);
      end else if (at_edge) begin
        err_d = 1'b1;
      end else if (neg_q) begin
        rem_d   = rem_q - OFFSET_BITS'(day_q);
        day_d   = dim_prev;
        month_d = prev_month;
        if (month_q == MONTH_JAN) begin
          year_d = year_q - 14'd1;
          if (ymod_q == 7'd0) begin
            ymod_d = YMOD_LAST;
            cmod_d = cmod_q - 2'd1;
          end else begin
            ymod_d = ymod_q - 7'd1;
          end
        end
      end else begin
        rem_d = rem_q - OFFSET_BITS'(room) - OFFSET_BITS'(1);
        day_d = 5'd1;
        if (month_q == MONTH_DEC) begin
          month_d = MONTH_JAN;
          year_d  = year_q + 14'd1;
          if (ymod_q == YMOD_LAST) begin
            ymod_d = 7'd0;
            cmod_d = cmod_q + 2'd1;
          end else begin
            ymod_d = ymod_q + 7'd1;
          end
        end else begin
          month_d = month_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sd_q  <= start_day_i;
      sm_q  <= start_month_i;
      sy_q  <= start_year_i;
      off_q <= day_offset_i;
    end
    if (cmd_i.calc_quot) begin
      quot_q <= quot_prod[DIV100_SHIFT +: 8];
    end
    if (cmd_i.check) begin
      neg_q <= off_q[OFFSET_BITS-1];
    end
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    rem_q   <= rem_d;
    ymod_q  <= ymod_d;
    cmod_q  <= cmod_d;
    err_q   <= err_d;
    if (cmd_i.load_out) begin
      // an error passes the start date through
      res_day_q   <= err_q ? sd_q : day_q;
      res_month_q <= err_q ? sm_q : month_q;
      res_year_q  <= err_q ? sy_q : year_q;
      res_err_q   <= err_q;
    end
  end

  assign result_day_o   = res_day_q;
  assign result_month_o = res_month_q;
  assign result_year_o  = res_year_q;
  assign error_o        = res_err_q;

  `DAD_ASSERT(a_step_month_ok, clk_i, rst_ni,
              !cmd_i.step || ((month_q >= MONTH_JAN) && (month_q <= MONTH_DEC)))
  `DAD_ASSERT(a_step_day_ok, clk_i, rst_ni,
              !cmd_i.step || ((day_q != 5'd0) && (day_q <= dim_cur)))
  `DAD_ASSERT(a_step_ymod_ok, clk_i, rst_ni,
              !cmd_i.step || (ymod_q <= YMOD_LAST))

endmodule

FILE: rtl/core/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer of the date adder: setup, month stepping and result hand-off.
// ----------------------------------------------------------------------------
`include "date_add_days_assert.svh"

module dad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dad_pkg::sts_t sts_i,
  output dad_pkg::cmd_t cmd_o
);
  import dad_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QUOT  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_STEP  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    state_d         = state_q;
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc_quot = (state_q == ST_QUOT);
    cmd_o.calc_mod  = (state_q == ST_MOD);
    cmd_o.check     = (state_q == ST_CHECK);
    cmd_o.step      = (state_q == ST_STEP);
    cmd_o.load_out  = (state_q == ST_DONE) && out_free;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_QUOT;
      ST_QUOT:  state_d = ST_MOD;
      ST_MOD:   state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.start_bad ? ST_DONE : ST_STEP;
      ST_STEP:  if (sts_i.step_done) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DAD_ASSERT_NEXT(a_load_out_valid, clk_i, rst_ni, cmd_o.load_out,
                   out_valid_q && (state_q == ST_IDLE))
  `DAD_ASSERT_NEXT(a_step_done_exit, clk_i, rst_ni, cmd_o.step && sts_i.step_done,
                   state_q == ST_DONE)
  `DAD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, cmd_o.load_in,
                   (state_q == ST_QUOT) && !in_ready_o)
  `DAD_ASSERT(a_single_cmd, clk_i, rst_ni,
              $onehot0({cmd_o.load_in, cmd_o.calc_quot, cmd_o.calc_mod,
                        cmd_o.check, cmd_o.step, cmd_o.load_out}))

endmodule

FILE: rtl/core/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days
// Adds a signed day offset to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// Usage:
// - in_ch carries start_day, start_month, start_year and day_offset; a transfer
//   happens when valid and ready are both high. ready is high only when the
//   block holds no item in work.
// - out_ch carries result_day, result_month, result_year and error, held in an
//   output register until the transfer completes.
// - after the input transfer: setup states QUOT, MOD and CHECK, then STEP,
//   one month boundary per step (about 17250 month steps for the largest
//   offset), then DONE. An invalid start date skips stepping; a year outside
//   1601..9999 stops at the range edge and flags error with the start date.
// - throughput: one item at a time; the month stepper sets the rate. The next
//   item is taken the cycle after the result enters the output register, even
//   while that result still waits.
// - a stalled receiver holds the finished item and stalls the next in DONE.
// - reset (rst_ni low, asynchronous) returns to idle and drops out valid.
// ----------------------------------------------------------------------------
module date_add_days (
  input  logic      clk_i,
  input  logic      rst_ni,
  dad_in_if.sink    in_ch,
  dad_out_if.source out_ch
);
  import dad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dad_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_day_i    (in_ch.start_day),
    .start_month_i  (in_ch.start_month),
    .start_year_i   (in_ch.start_year),
    .day_offset_i   (in_ch.day_offset),
    .result_day_o   (out_ch.result_day),
    .result_month_o (out_ch.result_month),
    .result_year_o  (out_ch.result_year),
    .error_o        (out_ch.error)
  );

endmodule

FILE: dv/date_add_days_tb.sv
// ----------------------------------------------------------------------------
// date_add_days_tb
// Self-checking bench for the date adder. A queue of start dates and day
// offsets feeds a valid/ready driver. A monitor predicts each result through
// day numbers and checks every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module date_add_days_tb;
  import dad_pkg::*;

  localparam int RANDOM_ITEMS = 80;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_AT     = 60;
  localparam int ERA_DAYS     = 146097;

  typedef struct {
    logic [4:0]                    day;
    logic [3:0]                    month;
    logic [13:0]                   year;
    logic signed [OFFSET_BITS-1:0] offset;
    bit                            drain_first;
  } date_req_t;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        error;
  } date_res_t;

  logic clk_i;
  logic rst_ni;

  dad_in_if  in_ch ();
  dad_out_if out_ch ();

  date_add_days u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_req_t pending_dates[$];
  date_res_t expected_dates[$];

  bit     in_accepted_q = 1'b0;
  bit     offering      = 1'b0;
  bit     hold_done     = 1'b0;
  int     hold_left     = 0;
  int     sent_count    = 0;
  int     items_accepted = 0;
  int     results_seen  = 0;
  int     mismatch_count = 0;
  int     total_items   = 0;
  int     directed_count = 0;
  longint cycle_count   = 0;
  longint cycle_budget  = 0;

  function automatic logic [4:0] month_length(input logic [3:0] m, input int y);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
      MONTH_FEB: return leap ? DAYS_FEB_LEAP : DAYS_FEB;
      default:   return DAYS_LONG;
    endcase
  endfunction

  // days since 0000-03-01, years counted from march so the leap day is last
  function automatic longint day_index(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mp, doy;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  function automatic void date_from_index(input longint z, output longint y,
                                          output longint m, output longint d);
    longint era, doe, yoe, doy, mp;
    era = z / ERA_DAYS;
    doe = z - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic date_res_t predict_date(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y,
                                             input logic signed [OFFSET_BITS-1:0] off);
    date_res_t res;
    longint    z, ny, nm, nd;
    // start date passes through whenever the flag is set
    res.day   = d;
    res.month = m;
    res.year  = y;
    res.error = 1'b1;
    if (y >= YEAR_MIN && y <= YEAR_MAX && m >= 1 && m <= 12 && d >= 1 &&
        d <= month_length(m, int'(y))) begin
      z = day_index(y, m, d) + longint'(off);
      if (z >= day_index(YEAR_MIN, 1, 1) && z <= day_index(YEAR_MAX, 12, 31)) begin
        date_from_index(z, ny, nm, nd);
        res.day   = nd[4:0];
        res.month = nm[3:0];
        res.year  = ny[13:0];
        res.error = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic add_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                          input logic signed [OFFSET_BITS-1:0] off, input bit drain);
    date_req_t req;
    longint    span;
    req.day         = d;
    req.month       = m;
    req.year        = y;
    req.offset      = off;
    req.drain_first = drain;
    pending_dates.push_back(req);
    span = longint'(off);
    if (span < 0) span = -span;
    // one month step per cycle plus setup and handshake slack
    cycle_budget += span / 28 + 80;
  endtask

  task automatic flag_mismatch(input string why, input date_res_t want, input date_res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch (%s): expected %0d-%0d-%0d err=%0b, got %0d-%0d-%0d err=%0b",
               why, want.year, want.month, want.day, want.error,
               got.year, got.month, got.day, got.error);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: holds an offered item until its transfer
  always @(negedge clk_i) begin : sender
    bit go;
    if (rst_ni) begin
      if (in_accepted_q) begin
        void'(pending_dates.pop_front());
        sent_count++;
        offering = 1'b0;
      end
      if (!offering && pending_dates.size() != 0) begin
        go = (sent_count >= directed_count + 65 && sent_count < directed_count + 85) ||
             ($urandom_range(99) >= IDLE_PCT);
        if (pending_dates[0].drain_first && expected_dates.size() != 0) go = 1'b0;
        if (go) begin
          offering = 1'b1;
          in_ch.start_day   <= pending_dates[0].day;
          in_ch.start_month <= pending_dates[0].month;
          in_ch.start_year  <= pending_dates[0].year;
          in_ch.day_offset  <= pending_dates[0].offset;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= directed_count + 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= directed_count + 65 && results_seen < directed_count + 85) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    date_res_t want, got;
    if (rst_ni) begin
      in_accepted_q <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        items_accepted++;
        expected_dates.push_back(predict_date(in_ch.start_day, in_ch.start_month,
                                              in_ch.start_year, in_ch.day_offset));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.day   = out_ch.result_day;
        got.month = out_ch.result_month;
        got.year  = out_ch.result_year;
        got.error = out_ch.error;
        if (expected_dates.size() == 0) begin
          want = '{default: '0};
          flag_mismatch("no result pending", want, got);
        end else begin
          want = expected_dates.pop_front();
          if (got.day !== want.day || got.month !== want.month ||
              got.year !== want.year || got.error !== want.error) begin
            flag_mismatch("wrong field", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0]                    d;
    logic [3:0]                    m;
    logic [13:0]                   y;
    logic signed [OFFSET_BITS-1:0] off;
    int                            pick, span;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.start_day    = '0;
    in_ch.start_month  = '0;
    in_ch.start_year   = '0;
    in_ch.day_offset   = '0;
    out_ch.ready       = 1'b0;

    // leap days, month and year wraps, range edges, offset extremes, bad dates
    add_date(5'd29, 4'd2, 14'd2000, 20'sd0, 1'b0);
    add_date(5'd29, 4'd2, 14'd1900, 20'sd0, 1'b0);
    add_date(5'd31, 4'd12, 14'd2024, 20'sd1, 1'b0);
    add_date(5'd1, 4'd3, 14'd2024, -20'sd1, 1'b0);
    add_date(5'd1, 4'd3, 14'd2100, -20'sd1, 1'b0);
    add_date(5'd28, 4'd2, 14'd2023, 20'sd1, 1'b0);
    add_date(5'd28, 4'd2, 14'd2024, 20'sd1, 1'b0);
    add_date(5'd1, 4'd1, 14'd1601, -20'sd1, 1'b0);
    add_date(5'd31, 4'd12, 14'd9999, 20'sd1, 1'b0);
    add_date(5'd31, 4'd12, 14'd9999, 20'sd0, 1'b0);
    add_date(5'd1, 4'd1, 14'd1601, 20'sd524287, 1'b0);
    add_date(5'd31, 4'd12, 14'd9999, -20'sd524288, 1'b0);
    add_date(5'd1, 4'd1, 14'd9999, 20'sd400, 1'b0);
    add_date(5'd10, 4'd6, 14'd1602, -20'sd600, 1'b0);
    add_date(5'd0, 4'd5, 14'd2020, 20'sd5, 1'b0);
    add_date(5'd31, 4'd4, 14'd2021, 20'sd5, 1'b0);
    add_date(5'd15, 4'd0, 14'd2020, 20'sd5, 1'b0);
    add_date(5'd15, 4'd13, 14'd2020, 20'sd5, 1'b0);
    add_date(5'd15, 4'd15, 14'd2020, 20'sd5, 1'b0);
    add_date(5'd1, 4'd1, 14'd1600, 20'sd5, 1'b0);
    add_date(5'd1, 4'd1, 14'd10000, 20'sd5, 1'b0);
    add_date(5'd31, 4'd15, 14'd16383, -20'sd1, 1'b0);
    add_date(5'd31, 4'd1, 14'd8191, -20'sd1, 1'b0);
    add_date(5'd30, 4'd9, 14'd2000, -20'sd40000, 1'b0);
    directed_count = pending_dates.size();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // raw fields, mostly bad start dates
        d   = 5'($urandom_range(31));
        m   = 4'($urandom_range(15));
        y   = 14'($urandom_range(16383));
        off = OFFSET_BITS'($urandom);
      end else begin
        if (pick < 22) begin
          y = $urandom_range(1) ? 14'($urandom_range(1610, 1601))
                                : 14'($urandom_range(9999, 9990));
        end else begin
          y = 14'($urandom_range(9999, 1601));
        end
        m    = 4'($urandom_range(12, 1));
        d    = 5'($urandom_range(month_length(m, int'(y)), 1));
        span = $urandom_range(99);
        // short offsets around the hold-off so the block fills quickly
        if ((k >= 25 && k < 45) || span < 65) begin
          off = OFFSET_BITS'(int'($urandom_range(4000)) - 2000);
        end else if (span < 90) begin
          off = OFFSET_BITS'(int'($urandom_range(80000)) - 40000);
        end else begin
          off = OFFSET_BITS'($urandom);
        end
      end
      add_date(d, m, y, off, k == DRAIN_AT);
    end
    total_items  = pending_dates.size();
    cycle_budget = 4 * (cycle_budget + 2000) + HOLD_CYCLES;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (items_accepted == total_items);
    wait (expected_dates.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
